[design/gbn_pkg.sv]
// Shared types, codes and defaults for the go-back-n sender window.
`timescale 1ns / 1ps

package gbn_pkg;

	localparam int WINDOW_DEPTH_DEF = 16;
	localparam int HANDLE_BITS_DEF  = 16;

	localparam logic [4:0]  WINDOW_SIZE_RST = 5'd16;
	localparam logic [7:0]  MAX_RETRIES_RST = 8'd10;
	localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
	localparam logic [31:0] MAGIC_RST       = 32'd0;
	localparam logic [7:0]  VERSION_RST     = 8'd1;

	typedef enum logic [2:0] {
		CMD_BEGIN = 3'd0,
		CMD_SEND  = 3'd1,
		CMD_ACK   = 3'd2,
		CMD_TICK  = 3'd3,
		CMD_FLUSH = 3'd4,
		CMD_ABORT = 3'd5
	} cmd_t;

	typedef enum logic [3:0] {
		ST_SENT       = 4'd0,
		ST_FULL       = 4'd1,
		ST_ABORTED    = 4'd2,
		ST_ACK_TAKEN  = 4'd3,
		ST_ACK_DROP   = 4'd4,
		ST_RESEND     = 4'd5,
		ST_RETRIES    = 4'd6,
		ST_IDLE       = 4'd7,
		ST_FLUSH_DONE = 4'd8,
		ST_BEGUN      = 4'd9
	} status_t;

	typedef enum logic [2:0] {
		CFG_WINDOW_SIZE = 3'd0,
		CFG_MAX_RETRIES = 3'd1,
		CFG_TIMEOUT     = 3'd2,
		CFG_MAGIC       = 3'd3,
		CFG_VERSION     = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		UPD_NONE,
		UPD_BEGIN,
		UPD_SEND,
		UPD_ACK,
		UPD_FLUSH_SET,
		UPD_FLUSH_CLR,
		UPD_ABORT,
		UPD_RETRY,
		UPD_RETRY_ABORT
	} upd_t;

	typedef enum logic [1:0] {
		TX_NONE,
		TX_SEND,
		TX_BURST
	} txsel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_TICK,
		S_ACK2,
		S_BURST
	} fsm_state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] packet_handle;
		logic [31:0] ack_number;
		logic        ack_flag_set;
		logic [31:0] ack_magic;
		logic [7:0]  ack_version;
		logic        checksum_ok;
	} item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic        tx_valid;
		logic [31:0] tx_sequence;
		logic [15:0] tx_handle;
		logic        last;
		logic [31:0] window_base;
		logic [4:0]  outstanding;
	} result_t;

	typedef struct packed {
		logic    capture;
		logic    tick_inc;
		upd_t    upd;
		logic    emit;
		status_t status;
		txsel_t  tx_sel;
		logic    last;
		logic    burst_start;
		logic    burst_step;
	} ctrl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       aborted;
		logic       full;
		logic       empty;
		logic       ack_ok;
		logic       flush_after_ack;
		logic       resend_due;
		logic       retry_over;
		logic       burst_last;
		logic       out_free;
	} stat_t;

endpackage

[design/gbn_ctrl.sv]
// Sequencer for the go-back-n sender window: decodes commands, drives the datapath.
`timescale 1ns / 1ps

module gbn_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  gbn_pkg::stat_t  stat,
	output gbn_pkg::ctrl_t  ctrl
);

	gbn_pkg::fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gbn_pkg::S_IDLE: begin
				if (item_valid) state_d = gbn_pkg::S_DECODE;
			end
			gbn_pkg::S_DECODE: begin
				if (stat.cmd == gbn_pkg::CMD_TICK) begin
					state_d = gbn_pkg::S_TICK;
				end else if (stat.out_free) begin
					if (stat.cmd == gbn_pkg::CMD_ACK && stat.ack_ok && stat.flush_after_ack)
						state_d = gbn_pkg::S_ACK2;
					else
						state_d = gbn_pkg::S_IDLE;
				end
			end
			gbn_pkg::S_TICK: begin
				if (stat.resend_due && !stat.retry_over) state_d = gbn_pkg::S_BURST;
				else if (stat.out_free) state_d = gbn_pkg::S_IDLE;
			end
			gbn_pkg::S_ACK2: begin
				if (stat.out_free) state_d = gbn_pkg::S_IDLE;
			end
			gbn_pkg::S_BURST: begin
				if (stat.out_free && stat.burst_last) state_d = gbn_pkg::S_IDLE;
			end
			default: state_d = gbn_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.upd = gbn_pkg::UPD_NONE;
		ctrl.status = gbn_pkg::ST_IDLE;
		ctrl.tx_sel = gbn_pkg::TX_NONE;
		item_ready = (state_q == gbn_pkg::S_IDLE);
		case (state_q)
			gbn_pkg::S_IDLE: begin
				ctrl.capture = item_valid;
			end
			gbn_pkg::S_DECODE: begin
				if (stat.cmd == gbn_pkg::CMD_TICK) begin
					ctrl.tick_inc = 1'b1;
				end else if (stat.out_free) begin
					ctrl.emit = 1'b1;
					ctrl.last = 1'b1;
					case (stat.cmd)
						gbn_pkg::CMD_BEGIN: begin
							ctrl.upd = gbn_pkg::UPD_BEGIN;
							ctrl.status = gbn_pkg::ST_BEGUN;
						end
						gbn_pkg::CMD_SEND: begin
							if (stat.aborted) begin
								ctrl.status = gbn_pkg::ST_ABORTED;
							end else if (stat.full) begin
								ctrl.status = gbn_pkg::ST_FULL;
							end else begin
								ctrl.upd = gbn_pkg::UPD_SEND;
								ctrl.status = gbn_pkg::ST_SENT;
								ctrl.tx_sel = gbn_pkg::TX_SEND;
							end
						end
						gbn_pkg::CMD_ACK: begin
							if (stat.ack_ok) begin
								ctrl.upd = gbn_pkg::UPD_ACK;
								ctrl.status = gbn_pkg::ST_ACK_TAKEN;
								ctrl.last = !stat.flush_after_ack;
							end else begin
								ctrl.status = gbn_pkg::ST_ACK_DROP;
							end
						end
						gbn_pkg::CMD_FLUSH: begin
							if (stat.aborted) begin
								ctrl.status = gbn_pkg::ST_ABORTED;
							end else if (stat.empty) begin
								ctrl.upd = gbn_pkg::UPD_FLUSH_CLR;
								ctrl.status = gbn_pkg::ST_FLUSH_DONE;
							end else begin
								ctrl.upd = gbn_pkg::UPD_FLUSH_SET;
								ctrl.status = gbn_pkg::ST_IDLE;
							end
						end
						gbn_pkg::CMD_ABORT: begin
							ctrl.upd = gbn_pkg::UPD_ABORT;
							ctrl.status = gbn_pkg::ST_ABORTED;
						end
						default: ctrl.status = gbn_pkg::ST_IDLE;
					endcase
				end
			end
			gbn_pkg::S_TICK: begin
				if (stat.resend_due && !stat.retry_over) begin
					ctrl.upd = gbn_pkg::UPD_RETRY;
					ctrl.burst_start = 1'b1;
				end else if (stat.out_free) begin
					ctrl.emit = 1'b1;
					ctrl.last = 1'b1;
					if (stat.resend_due) begin
						ctrl.upd = gbn_pkg::UPD_RETRY_ABORT;
						ctrl.status = gbn_pkg::ST_RETRIES;
					end else begin
						ctrl.status = gbn_pkg::ST_IDLE;
					end
				end
			end
			gbn_pkg::S_ACK2: begin
				if (stat.out_free) begin
					ctrl.emit = 1'b1;
					ctrl.last = 1'b1;
					ctrl.upd = gbn_pkg::UPD_FLUSH_CLR;
					ctrl.status = gbn_pkg::ST_FLUSH_DONE;
				end
			end
			gbn_pkg::S_BURST: begin
				if (stat.out_free) begin
					ctrl.emit = 1'b1;
					ctrl.status = gbn_pkg::ST_RESEND;
					ctrl.tx_sel = gbn_pkg::TX_BURST;
					ctrl.last = stat.burst_last;
					ctrl.burst_step = !stat.burst_last;
				end
			end
			default: ;
		endcase
	end

endmodule

[design/gbn_datapath.sv]
// Window state, slot memory, configuration registers and result register.
`timescale 1ns / 1ps

module gbn_datapath #(
	parameter int WINDOW_DEPTH = gbn_pkg::WINDOW_DEPTH_DEF,
	parameter int HANDLE_BITS  = gbn_pkg::HANDLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gbn_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             result_ready,
	output logic             result_valid,
	output gbn_pkg::result_t result,
	input  gbn_pkg::ctrl_t   ctrl,
	output gbn_pkg::stat_t   stat
);

	localparam int IDX_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int MEM_DEPTH = 1 << IDX_W;
	localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
	localparam int HW        = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

	logic [4:0]  window_size_q;
	logic [7:0]  max_retries_q;
	logic [15:0] timeout_q;
	logic [31:0] magic_q;
	logic [7:0]  version_q;

	logic [31:0] base_q, next_q, tick_q;
	logic [7:0]  retry_q;
	logic        aborted_q, flushing_q;
	logic [31:0] base_d, next_d;
	logic [7:0]  retry_d, retry_inc;
	logic        aborted_d, flushing_d;

	gbn_pkg::item_t item_q;
	logic [CNT_W-1:0] burst_q;

	logic [HW-1:0] hmem [MEM_DEPTH];
	logic [31:0]   tmem [MEM_DEPTH];
	logic [HW-1:0] rd_handle_q;
	logic [31:0]   rd_time_q;
	logic          rd_en;
	logic [IDX_W-1:0] rd_addr, next_idx, burst_idx;

	logic [31:0] count, eff_win, ack_plus, burst_seq, burst_seq_nx, age;
	logic        result_valid_q;
	gbn_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= gbn_pkg::WINDOW_SIZE_RST;
			max_retries_q <= gbn_pkg::MAX_RETRIES_RST;
			timeout_q     <= gbn_pkg::TIMEOUT_RST;
			magic_q       <= gbn_pkg::MAGIC_RST;
			version_q     <= gbn_pkg::VERSION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gbn_pkg::CFG_WINDOW_SIZE: window_size_q <= cfg_data[4:0];
				gbn_pkg::CFG_MAX_RETRIES: max_retries_q <= cfg_data[7:0];
				gbn_pkg::CFG_TIMEOUT:     timeout_q     <= cfg_data[15:0];
				gbn_pkg::CFG_MAGIC:       magic_q       <= cfg_data;
				gbn_pkg::CFG_VERSION:     version_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign count    = next_q - base_q;
	assign ack_plus = item_q.ack_number + 32'd1;
	assign age      = tick_q - rd_time_q;
	assign burst_seq    = base_q + 32'(burst_q);
	assign burst_seq_nx = burst_seq + 32'd1;
	assign next_idx  = next_q[IDX_W-1:0];
	assign burst_idx = burst_seq[IDX_W-1:0];

	always_comb begin
		if (window_size_q == 5'd0)
			eff_win = 32'd1;
		else if (32'(window_size_q) > 32'(WINDOW_DEPTH))
			eff_win = 32'(WINDOW_DEPTH);
		else
			eff_win = 32'(window_size_q);
	end

	assign retry_inc = (retry_q == 8'hFF) ? 8'hFF : retry_q + 8'd1;

	always_comb begin
		base_d = base_q;
		next_d = next_q;
		retry_d = retry_q;
		aborted_d = aborted_q;
		flushing_d = flushing_q;
		case (ctrl.upd)
			gbn_pkg::UPD_BEGIN: begin
				base_d = '0;
				next_d = '0;
				retry_d = '0;
				aborted_d = 1'b0;
				flushing_d = 1'b0;
			end
			gbn_pkg::UPD_SEND: begin
				next_d = next_q + 32'd1;
				retry_d = '0;
			end
			gbn_pkg::UPD_ACK: begin
				base_d = ack_plus;
				retry_d = '0;
			end
			gbn_pkg::UPD_FLUSH_SET: flushing_d = 1'b1;
			gbn_pkg::UPD_FLUSH_CLR: flushing_d = 1'b0;
			gbn_pkg::UPD_ABORT: begin
				aborted_d = 1'b1;
				flushing_d = 1'b0;
			end
			gbn_pkg::UPD_RETRY: retry_d = retry_inc;
			gbn_pkg::UPD_RETRY_ABORT: begin
				retry_d = retry_inc;
				aborted_d = 1'b1;
				flushing_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			next_q <= '0;
			retry_q <= '0;
			tick_q <= '0;
			aborted_q <= 1'b0;
			flushing_q <= 1'b0;
			burst_q <= '0;
		end else begin
			base_q <= base_d;
			next_q <= next_d;
			retry_q <= retry_d;
			aborted_q <= aborted_d;
			flushing_q <= flushing_d;
			if (ctrl.tick_inc) tick_q <= tick_q + 32'd1;
			if (ctrl.burst_start) burst_q <= '0;
			else if (ctrl.burst_step) burst_q <= burst_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) item_q <= item;
	end

	// slot memory: one write, one registered read per cycle
	assign rd_en   = ctrl.capture | ctrl.burst_start | ctrl.burst_step;
	assign rd_addr = ctrl.burst_step ? burst_seq_nx[IDX_W-1:0] : base_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.upd == gbn_pkg::UPD_SEND) begin
			hmem[next_idx] <= item_q.packet_handle[HW-1:0];
			tmem[next_idx] <= tick_q;
		end else if (ctrl.emit && ctrl.tx_sel == gbn_pkg::TX_BURST) begin
			tmem[burst_idx] <= tick_q;
		end
		if (rd_en) begin
			rd_handle_q <= hmem[rd_addr];
			rd_time_q <= tmem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			result_q.status <= ctrl.status;
			result_q.tx_valid <= (ctrl.tx_sel != gbn_pkg::TX_NONE);
			result_q.last <= ctrl.last;
			result_q.window_base <= base_d;
			result_q.outstanding <= 5'(next_d - base_d);
			case (ctrl.tx_sel)
				gbn_pkg::TX_SEND: begin
					result_q.tx_sequence <= next_q;
					result_q.tx_handle <= 16'(item_q.packet_handle[HW-1:0]);
				end
				gbn_pkg::TX_BURST: begin
					result_q.tx_sequence <= burst_seq;
					result_q.tx_handle <= 16'(rd_handle_q);
				end
				default: begin
					result_q.tx_sequence <= '0;
					result_q.tx_handle <= '0;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	assign stat.cmd = item_q.command;
	assign stat.aborted = aborted_q;
	assign stat.full = (count >= eff_win);
	assign stat.empty = (count == 32'd0);
	assign stat.ack_ok = item_q.checksum_ok && item_q.ack_flag_set &&
		(item_q.ack_version == version_q) && (item_q.ack_magic == magic_q) &&
		((item_q.ack_number - base_q) < count);
	assign stat.flush_after_ack = flushing_q && (next_q == ack_plus);
	assign stat.resend_due = !aborted_q && (count != 32'd0) &&
		((count >= eff_win) || flushing_q) && (age >= 32'(timeout_q));
	assign stat.retry_over = ({1'b0, retry_q} + 9'd1) > {1'b0, max_retries_q};
	assign stat.burst_last = ((32'(burst_q) + 32'd1) == count);
	assign stat.out_free = !result_valid_q || result_ready;

endmodule

[design/go_back_n_sender_window.sv]
// Go-back-n sender window top level.
// Items are taken one at a time. Begin, send, ack, flush and abort are decoded in S_DECODE and
// their result is registered; an ack that empties a flushing window gives a second result
// from S_ACK2. A tick passes through S_DECODE and S_TICK, and when it resends the window it
// gives one resent packet per cycle while the result side does not stall, paced by the
// registered read port of the slot memory. Any stall on the result side delays these steps.
// The block holds no clearing pass after reset; slot contents are used only once written.
`timescale 1ns / 1ps

module go_back_n_sender_window #(
	parameter int WINDOW_DEPTH = gbn_pkg::WINDOW_DEPTH_DEF,
	parameter int HANDLE_BITS  = gbn_pkg::HANDLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  gbn_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output gbn_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	gbn_pkg::ctrl_t ctrl;
	gbn_pkg::stat_t stat;

	gbn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	gbn_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.HANDLE_BITS  (HANDLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.ctrl         (ctrl),
		.stat         (stat)
	);

endmodule

[design/gbn_checker.sv]
// Port-level assertions for the go-back-n sender window, bound to the top level.
`timescale 1ns / 1ps

module gbn_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input gbn_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_ready,
	input gbn_pkg::result_t result,
	input logic             cfg_we,
	input logic [2:0]       cfg_index,
	input logic [31:0]      cfg_data
);

	// only sends and resends carry a packet
	a_tx_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.tx_valid |->
			(result.status == 4'(gbn_pkg::ST_SENT) || result.status == 4'(gbn_pkg::ST_RESEND)))
		else $error("tx on non-transmit status");

	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.tx_valid |->
			(result.tx_sequence == 32'd0 && result.tx_handle == 16'd0))
		else $error("tx fields not zero");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready right after transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (.*);
